[hdl/rpmc_pkg.sv]
package rpmc_pkg;

	typedef enum logic [2:0] {
		MODE_PASS    = 3'd0,
		MODE_RECORD  = 3'd1,
		MODE_ARMED   = 3'd2,
		MODE_PLAYING = 3'd3,
		MODE_ERROR   = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		CMD_MODE_SET       = 3'd0,
		CMD_PLAY_START     = 3'd1,
		CMD_PLAY_ABORT     = 3'd2,
		CMD_PLAY_FINISH    = 3'd3,
		CMD_PROTOCOL_FAULT = 3'd4,
		CMD_LINK_FAULT     = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		RSN_OK         = 3'd0,
		RSN_BAD_TARGET = 3'd1,
		RSN_BAD_TRANS  = 3'd2,
		RSN_ABORTED    = 3'd3,
		RSN_FINISHED   = 3'd4,
		RSN_PROTOCOL   = 3'd5,
		RSN_LINK       = 3'd6
	} reason_t;

	localparam int unsigned CommandWidth = 3;
	localparam int unsigned TargetWidth  = 8;

	// one captured command transaction
	typedef struct packed {
		logic [CommandWidth-1:0] command;
		logic [TargetWidth-1:0]  target;
	} item_t;

	// one result transaction
	typedef struct packed {
		mode_t   mode_now;
		reason_t reason;
		logic    accepted;
		logic    flush_queue;
		logic    flush_keys;
		logic    release_all;
		logic    physical_allowed;
		logic    recording;
	} result_t;

endpackage

[hdl/record_playback_mode_controller_top.sv]
// channel | valid      | stall      | payload
// cmd     | cmd_valid  | cmd_stall  | command, target
// rslt    | rslt_valid | rslt_stall | mode_now, reason, accepted, flush_queue,
//         |            |            | flush_keys, release_all,
//         |            |            | physical_allowed, recording
// one transaction per cycle sustained while rslt_stall is low; a command passes through
// the input register, then the result register, before its result is offered
// the mode register updates as the command leaves the input register
// arst_n clears both valid flags and puts the mode at pass
// a stalled result holds its payload; cmd_stall rises only when both stages are full and rslt_stall is high
module record_playback_mode_controller_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [2:0] command,
	input  logic [7:0] target,
	output logic       rslt_valid,
	input  logic       rslt_stall,
	output logic [2:0] mode_now,
	output logic [2:0] reason,
	output logic       accepted,
	output logic       flush_queue,
	output logic       flush_keys,
	output logic       release_all,
	output logic       physical_allowed,
	output logic       recording
);
	import rpmc_pkg::*;

	logic    valid_s1;
	logic    advance;
	item_t   item_s1;
	result_t result;
	result_t result_s2;

	// input register: captures command transactions
	rpmc_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (command),
		.target    (target),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	// mode register and decode of the registered command
	rpmc_mode_fsm u_mode_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (valid_s1 && advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	// result register toward the consumer
	rpmc_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.result     (result),
		.rslt_stall (rslt_stall),
		.advance    (advance),
		.rslt_valid (rslt_valid),
		.result_s2  (result_s2)
	);

	// pulses are qualified by rslt_valid; each lasts one transaction
	assign mode_now         = result_s2.mode_now;
	assign reason           = result_s2.reason;
	assign accepted         = result_s2.accepted;
	assign flush_queue      = result_s2.flush_queue;
	assign flush_keys       = result_s2.flush_keys;
	assign release_all      = result_s2.release_all;
	assign physical_allowed = result_s2.physical_allowed;
	assign recording        = result_s2.recording;

endmodule

[hdl/rpmc_in_stage.sv]
module rpmc_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  logic [2:0]     command,
	input  logic [7:0]     target,
	input  logic           advance,
	output logic           valid_s1,
	output rpmc_pkg::item_t item_s1
);
	import rpmc_pkg::*;

	logic load;

	// stage may refill when empty or when its item moves on this cycle
	assign cmd_stall = valid_s1 && !advance;
	assign load      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.command <= command;
			item_s1.target  <= target;
		end
	end

endmodule

[hdl/rpmc_mode_fsm.sv]
module rpmc_mode_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  rpmc_pkg::item_t   item_s1,
	output rpmc_pkg::result_t result
);
	import rpmc_pkg::*;

	mode_t   mode_q;
	mode_t   mode_nxt;
	mode_t   tgt_mode;
	logic    tgt_ok;
	logic    tgt_pass;
	reason_t reason;
	logic    ok;
	logic    clr_q;
	logic    phys;

	// valid targets are pass, record and armed
	assign tgt_ok   = (item_s1.target[7:2] == 6'd0) && (item_s1.target[1:0] != 2'b11);
	assign tgt_mode = mode_t'({1'b0, item_s1.target[1:0]});
	assign tgt_pass = (item_s1.target == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PASS;
		end else if (fire) begin
			mode_q <= mode_nxt;
		end
	end

	always_comb begin
		mode_nxt = mode_q;
		unique case (item_s1.command)
			CMD_MODE_SET: begin
				if (tgt_ok) begin
					if (tgt_pass) begin
						mode_nxt = MODE_PASS;
					end else if (mode_q == MODE_PASS) begin
						mode_nxt = tgt_mode;
					end
				end
			end
			CMD_PLAY_START: begin
				if (mode_q == MODE_ARMED) begin
					mode_nxt = MODE_PLAYING;
				end
			end
			CMD_PLAY_ABORT: begin
				if (mode_q == MODE_ARMED || mode_q == MODE_PLAYING) begin
					mode_nxt = MODE_ARMED;
				end
			end
			CMD_PLAY_FINISH: begin
				if (mode_q == MODE_PLAYING) begin
					mode_nxt = MODE_ARMED;
				end
			end
			CMD_PROTOCOL_FAULT, CMD_LINK_FAULT: begin
				if (mode_q != MODE_PASS && mode_q != MODE_ERROR) begin
					mode_nxt = MODE_ERROR;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		reason = RSN_BAD_TRANS;
		ok     = 1'b0;
		clr_q  = 1'b0;
		phys   = 1'b0;
		unique case (item_s1.command)
			CMD_MODE_SET: begin
				if (!tgt_ok) begin
					reason = RSN_BAD_TARGET;
				end else if (tgt_pass) begin
					reason = RSN_OK;
					ok     = 1'b1;
					clr_q  = (mode_q != MODE_PASS);
					phys   = (mode_q != MODE_PASS);
				end else if (tgt_mode == mode_q) begin
					reason = RSN_OK;
					ok     = 1'b1;
				end else if (mode_q == MODE_PASS) begin
					reason = RSN_OK;
					ok     = 1'b1;
					clr_q  = 1'b1;
					phys   = 1'b1;
				end
			end
			CMD_PLAY_START: begin
				if (mode_q == MODE_ARMED) begin
					reason = RSN_OK;
					ok     = 1'b1;
					phys   = 1'b1;
				end
			end
			CMD_PLAY_ABORT: begin
				if (mode_q == MODE_ARMED || mode_q == MODE_PLAYING) begin
					reason = RSN_ABORTED;
					ok     = 1'b1;
					clr_q  = 1'b1;
					phys   = 1'b1;
				end
			end
			CMD_PLAY_FINISH: begin
				if (mode_q == MODE_PLAYING) begin
					reason = RSN_FINISHED;
					ok     = 1'b1;
					clr_q  = 1'b1;
					phys   = 1'b1;
				end
			end
			CMD_PROTOCOL_FAULT, CMD_LINK_FAULT: begin
				reason = (item_s1.command == CMD_PROTOCOL_FAULT) ? RSN_PROTOCOL : RSN_LINK;
				ok     = 1'b1;
				// pass only reports, error is already latched
				clr_q  = (mode_q != MODE_PASS && mode_q != MODE_ERROR);
				phys   = (mode_q != MODE_PASS && mode_q != MODE_ERROR);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.mode_now         = mode_nxt;
		result.reason           = reason;
		result.accepted         = ok;
		result.flush_queue      = clr_q;
		result.flush_keys       = phys;
		result.release_all      = phys;
		result.physical_allowed = (mode_nxt == MODE_PASS || mode_nxt == MODE_RECORD);
		result.recording        = (mode_nxt == MODE_RECORD);
	end

endmodule

[hdl/rpmc_out_stage.sv]
module rpmc_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  rpmc_pkg::result_t result,
	input  logic              rslt_stall,
	output logic              advance,
	output logic              rslt_valid,
	output rpmc_pkg::result_t result_s2
);
	import rpmc_pkg::*;

	// register takes a new transaction when empty or being drained
	assign advance = !rslt_valid || !rslt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rslt_valid <= 1'b0;
		end else if (advance) begin
			rslt_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

endmodule

[hdl/rpmc_checker.sv]
module rpmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rslt_valid,
	input logic       rslt_stall,
	input logic [2:0] mode_now,
	input logic       accepted,
	input logic       flush_queue,
	input logic       flush_keys,
	input logic       release_all,
	input logic       physical_allowed,
	input logic       recording
);
	import rpmc_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rslt_valid && rslt_stall |=> rslt_valid && $stable(mode_now))
		else $error("result changed while stalled");

	a_release_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rslt_valid |-> release_all == flush_keys)
		else $error("release_all and flush_keys differ");

	a_rejected_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rslt_valid && !accepted |-> !flush_queue && !flush_keys)
		else $error("pulse on rejected command");

	a_record_phys: assert property (@(posedge clk) disable iff (!arst_n)
		rslt_valid && recording |-> physical_allowed && mode_now == MODE_RECORD)
		else $error("recording outside record mode");

endmodule

bind record_playback_mode_controller_top rpmc_checker u_rpmc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rslt_valid       (rslt_valid),
	.rslt_stall       (rslt_stall),
	.mode_now         (mode_now),
	.accepted         (accepted),
	.flush_queue      (flush_queue),
	.flush_keys       (flush_keys),
	.release_all      (release_all),
	.physical_allowed (physical_allowed),
	.recording        (recording)
);

[dv/testbench.sv]
module testbench;
	import rpmc_pkg::*;

	// commands outside the defined set, which the block must ignore
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	// mode set targets as they travel on the 8-bit target field
	localparam logic [7:0] TGT_PASS    = 8'(MODE_PASS);
	localparam logic [7:0] TGT_RECORD  = 8'(MODE_RECORD);
	localparam logic [7:0] TGT_ARMED   = 8'(MODE_ARMED);
	localparam logic [7:0] TGT_PLAYING = 8'(MODE_PLAYING);
	localparam logic [7:0] TGT_ERROR   = 8'(MODE_ERROR);
	localparam logic [7:0] TGT_MAX     = 8'hFF;

	localparam int RandomItems  = 600;
	localparam int BackToBack   = 100;
	localparam int DrainCycles  = 2000;
	localparam int TailCycles   = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	logic [2:0] command = 3'd0;
	logic [7:0] target = 8'd0;
	logic       rslt_valid;
	logic       rslt_stall = 1'b0;
	logic [2:0] mode_now;
	logic [2:0] reason;
	logic       accepted;
	logic       flush_queue;
	logic       flush_keys;
	logic       release_all;
	logic       physical_allowed;
	logic       recording;

	// predicted controller mode, kept in step with every accepted command
	mode_t      ctl_mode = MODE_PASS;
	// outcomes predicted for taken commands, oldest first
	result_t    pending_outcomes[$];
	int         error_count = 0;
	int         cmds_sent = 0;
	// random idling switches for the command and result sides
	bit         cmd_idle_on = 1'b0;
	bit         rslt_idle_on = 1'b0;

	record_playback_mode_controller_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.command          (command),
		.target           (target),
		.rslt_valid       (rslt_valid),
		.rslt_stall       (rslt_stall),
		.mode_now         (mode_now),
		.reason           (reason),
		.accepted         (accepted),
		.flush_queue      (flush_queue),
		.flush_keys       (flush_keys),
		.release_all      (release_all),
		.physical_allowed (physical_allowed),
		.recording        (recording)
	);

	// 8 unit clock period
	initial begin : clock_gen
		forever begin
			#4 clk = ~clk;
		end
	end

	// generous overall limit, far above the slowest correct run
	initial begin : run_limit
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// next-state and outcome of the mode controller for one command
	function automatic result_t step_mode_logic(input logic [2:0] cmd, input logic [7:0] tgt);
		result_t r;
		mode_t   m;
		logic    pulse_q;
		logic    pulse_phys;
		m = ctl_mode;
		r.reason = RSN_BAD_TRANS;
		r.accepted = 1'b0;
		pulse_q = 1'b0;
		pulse_phys = 1'b0;
		case (cmd)
			CMD_MODE_SET: begin
				if (tgt > TGT_ARMED) begin
					r.reason = RSN_BAD_TARGET;
				end else if (tgt == TGT_PASS) begin
					// leaving any mode for pass flushes everything
					if (m != MODE_PASS) begin
						pulse_q = 1'b1;
						pulse_phys = 1'b1;
						m = MODE_PASS;
					end
					r.reason = RSN_OK;
					r.accepted = 1'b1;
				end else if (tgt == 8'(m)) begin
					// same mode again: success, no pulses
					r.reason = RSN_OK;
					r.accepted = 1'b1;
				end else if (m == MODE_PASS) begin
					pulse_q = 1'b1;
					pulse_phys = 1'b1;
					m = mode_t'(tgt[2:0]);
					r.reason = RSN_OK;
					r.accepted = 1'b1;
				end
			end
			CMD_PLAY_START: begin
				// playback keeps its queue, only key state is cleared
				if (m == MODE_ARMED) begin
					pulse_phys = 1'b1;
					m = MODE_PLAYING;
					r.reason = RSN_OK;
					r.accepted = 1'b1;
				end
			end
			CMD_PLAY_ABORT: begin
				if (m == MODE_ARMED || m == MODE_PLAYING) begin
					pulse_q = 1'b1;
					pulse_phys = 1'b1;
					m = MODE_ARMED;
					r.reason = RSN_ABORTED;
					r.accepted = 1'b1;
				end
			end
			CMD_PLAY_FINISH: begin
				if (m == MODE_PLAYING) begin
					pulse_q = 1'b1;
					pulse_phys = 1'b1;
					m = MODE_ARMED;
					r.reason = RSN_FINISHED;
					r.accepted = 1'b1;
				end
			end
			CMD_PROTOCOL_FAULT, CMD_LINK_FAULT: begin
				// pass and error only report the fault
				if (m != MODE_PASS && m != MODE_ERROR) begin
					pulse_q = 1'b1;
					pulse_phys = 1'b1;
					m = MODE_ERROR;
				end
				r.reason = (cmd == CMD_PROTOCOL_FAULT) ? RSN_PROTOCOL : RSN_LINK;
				r.accepted = 1'b1;
			end
			default: begin
				// reserved commands leave everything alone
			end
		endcase
		ctl_mode = m;
		r.mode_now = m;
		r.flush_queue = pulse_q;
		r.flush_keys = pulse_phys;
		r.release_all = pulse_phys;
		r.physical_allowed = (m == MODE_PASS || m == MODE_RECORD);
		r.recording = (m == MODE_RECORD);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// present one command transaction and hold it until the block takes it
	task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] tgt);
		int gap;
		if (cmd_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= cmd;
		target <= tgt;
		@(posedge clk);
		while (cmd_stall !== 1'b0) @(posedge clk);
		// taken at this edge
		pending_outcomes.push_back(step_mode_logic(cmd, tgt));
		cmds_sent++;
	endtask

	// any command other than mode set, with a random target field
	task automatic send_play(input logic [2:0] cmd);
		send_cmd(cmd, 8'($urandom_range(0, 255)));
	endtask

	// take the command side quiet and wait until every outcome has come back
	task automatic drain_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	// result side: random stall bursts and comparison of each taken transaction
	initial begin : result_check
		result_t want;
		int      hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (rslt_valid === 1'b1 && rslt_stall === 1'b0) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch("unexpected result, mode_now", mode_now, 0);
				end else begin
					want = pending_outcomes.pop_front();
					if (mode_now !== want.mode_now)
						report_mismatch("mode_now", mode_now, want.mode_now);
					if (reason !== want.reason)
						report_mismatch("reason", reason, want.reason);
					if (accepted !== want.accepted)
						report_mismatch("accepted", accepted, want.accepted);
					if (flush_queue !== want.flush_queue)
						report_mismatch("flush_queue", flush_queue, want.flush_queue);
					if (flush_keys !== want.flush_keys)
						report_mismatch("flush_keys", flush_keys, want.flush_keys);
					if (release_all !== want.release_all)
						report_mismatch("release_all", release_all, want.release_all);
					if (physical_allowed !== want.physical_allowed)
						report_mismatch("physical_allowed", physical_allowed,
							want.physical_allowed);
					if (recording !== want.recording)
						report_mismatch("recording", recording, want.recording);
				end
			end
			// stall bursts, each ending when the hold counter counts down to zero
			if (hold > 0) begin
				hold--;
				if (hold == 0)
					rslt_stall <= 1'b0;
			end else if (rslt_idle_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 15);
				rslt_stall <= 1'b1;
			end
		end
	end

	// mode set paths out of pass, same-mode requests and bad targets
	task automatic test_mode_set();
		send_cmd(CMD_MODE_SET, TGT_PASS);
		send_cmd(CMD_MODE_SET, TGT_RECORD);
		send_cmd(CMD_MODE_SET, TGT_RECORD);
		send_cmd(CMD_MODE_SET, TGT_ARMED);
		send_cmd(CMD_MODE_SET, TGT_PASS);
		send_cmd(CMD_MODE_SET, TGT_ARMED);
		send_cmd(CMD_MODE_SET, TGT_RECORD);
		send_cmd(CMD_MODE_SET, TGT_PLAYING);
		send_cmd(CMD_MODE_SET, TGT_MAX);
	endtask

	// playback start, finish and abort from the allowed and refused modes
	task automatic test_playback();
		send_play(CMD_PLAY_FINISH);
		send_play(CMD_PLAY_START);
		send_play(CMD_PLAY_START);
		send_play(CMD_PLAY_FINISH);
		send_play(CMD_PLAY_START);
		send_play(CMD_PLAY_ABORT);
		send_play(CMD_PLAY_ABORT);
		send_cmd(CMD_MODE_SET, TGT_PASS);
		send_play(CMD_PLAY_START);
		send_play(CMD_PLAY_ABORT);
	endtask

	// faults in pass, in record and in error, then recovery; reserved commands
	task automatic test_faults();
		send_cmd(CMD_PROTOCOL_FAULT, 8'h00);
		send_cmd(CMD_LINK_FAULT, TGT_MAX);
		send_cmd(CMD_MODE_SET, TGT_RECORD);
		send_cmd(CMD_PROTOCOL_FAULT, 8'h5A);
		send_cmd(CMD_LINK_FAULT, 8'hA5);
		send_cmd(CMD_MODE_SET, TGT_ERROR);
		send_cmd(CMD_MODE_SET, TGT_RECORD);
		send_play(CMD_PLAY_START);
		send_cmd(CMD_RSVD6, 8'h00);
		send_cmd(CMD_MODE_SET, TGT_PASS);
		send_cmd(CMD_RSVD7, TGT_MAX);
	endtask

	// one random session; mostly well formed flows with random detail
	task automatic random_session();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind <= 2) begin
			// recording session
			send_cmd(CMD_MODE_SET, TGT_RECORD);
			n = $urandom_range(0, 3);
			repeat (n) begin
				if ($urandom_range(0, 1) == 0)
					send_cmd(CMD_MODE_SET, TGT_RECORD);
				else
					send_play(3'($urandom_range(1, 3)));
			end
			if ($urandom_range(0, 4) == 0)
				send_play(3'($urandom_range(4, 5)));
			send_cmd(CMD_MODE_SET, TGT_PASS);
		end else if (kind <= 6) begin
			// playback session with finishes and aborts
			send_cmd(CMD_MODE_SET, TGT_ARMED);
			n = $urandom_range(1, 4);
			repeat (n) begin
				send_play(CMD_PLAY_START);
				if ($urandom_range(0, 1) == 0)
					send_play(CMD_PLAY_FINISH);
				else
					send_play(CMD_PLAY_ABORT);
				if ($urandom_range(0, 5) == 0)
					send_cmd(CMD_MODE_SET, 8'($urandom_range(0, 3)));
			end
			if ($urandom_range(0, 4) == 0)
				send_play(3'($urandom_range(4, 5)));
			send_cmd(CMD_MODE_SET, TGT_PASS);
		end else if (kind == 7) begin
			// fault while active, then random commands stuck in error
			send_cmd(CMD_MODE_SET, 8'($urandom_range(1, 2)));
			if ($urandom_range(0, 1) == 0)
				send_play(CMD_PLAY_START);
			send_play(3'($urandom_range(4, 5)));
			n = $urandom_range(0, 4);
			repeat (n) send_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			send_cmd(CMD_MODE_SET, TGT_PASS);
		end else begin
			// noise, half of it with targets near the valid range
			n = $urandom_range(1, 6);
			repeat (n) begin
				if ($urandom_range(0, 1) == 0)
					send_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 3)));
				else
					send_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// random sessions with idling on both sides, some stretches without
	task automatic test_random_sessions();
		while (cmds_sent < RandomItems) begin
			cmd_idle_on = ($urandom_range(0, 3) != 0);
			rslt_idle_on = ($urandom_range(0, 3) != 0);
			random_session();
		end
	endtask

	// sender holds off until the pipeline is empty, then picks up again
	task automatic test_drain_pause();
		cmd_idle_on = 1'b1;
		rslt_idle_on = 1'b1;
		send_cmd(CMD_MODE_SET, TGT_ARMED);
		send_play(CMD_PLAY_START);
		drain_results();
		send_play(CMD_PLAY_FINISH);
		send_cmd(CMD_MODE_SET, TGT_PASS);
	endtask

	// closing stretch at full rate, no idling anywhere
	task automatic test_back_to_back();
		int start;
		cmd_idle_on = 1'b0;
		rslt_idle_on = 1'b0;
		start = cmds_sent;
		while (cmds_sent < start + BackToBack)
			random_session();
	endtask

	initial begin : stimulus
		// reset held at start, released on a rising edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_mode_set();
		test_playback();
		test_faults();
		test_drain_pause();
		test_random_sessions();
		test_back_to_back();

		// let the pipeline empty, bounded
		cmd_valid <= 1'b0;
		for (int i = 0; i < DrainCycles && pending_outcomes.size() != 0; i++)
			@(posedge clk);
		if (pending_outcomes.size() != 0)
			report_mismatch("results missing", pending_outcomes.size(), 0);
		// an idle tail to catch stray results
		repeat (TailCycles) @(posedge clk);

		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
